### rtl/vpim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpim_pkg
// Shared widths, defaults and register indexes for the padded volume index map.
// ----------------------------------------------------------------------------
package vpim_pkg;
	localparam int IDX_W     = 35;
	localparam int SRC_W     = 30;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 3;
	localparam int DEN_W     = CFG_W + 2;

	localparam int MAX_SIZE_DEF = 1024;
	localparam int MAX_PAD_DEF  = 1024;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH  = 3'd0,
		REG_SRC_HEIGHT = 3'd1,
		REG_SRC_DEPTH  = 3'd2,
		REG_PAD_LEFT   = 3'd3,
		REG_PAD_RIGHT  = 3'd4,
		REG_PAD_FRONT  = 3'd5,
		REG_PAD_BACK   = 3'd6,
		REG_PAD_BOTTOM = 3'd7
	} reg_idx_t;
endpackage

### rtl/vpim_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpim_div
// Pipelined restoring divider, one quotient bit per stage, side data carried.
// ----------------------------------------------------------------------------
module vpim_div
	import vpim_pkg::*;
#(
	parameter int NUM_W = IDX_W,
	parameter int DW    = DEN_W,
	parameter int AUX_W = DEN_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  logic [NUM_W-1:0] num,
	input  logic [DW-1:0]    den,
	input  logic [AUX_W-1:0] in_aux,
	output logic             out_vld,
	output logic [NUM_W-1:0] quot,
	output logic [DW-1:0]    rem,
	output logic [AUX_W-1:0] out_aux
);
	logic [NUM_W-1:0] vld_s;
	logic [DW-1:0]    rem_s [NUM_W];
	logic [NUM_W-1:0] wrk_s [NUM_W];
	logic [AUX_W-1:0] aux_s [NUM_W];

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic             v_in;
		logic [DW-1:0]    r_in;
		logic [NUM_W-1:0] w_in;
		logic [AUX_W-1:0] a_in;
		logic [DW:0]      t;
		logic [DW:0]      diff;
		logic             ge;

		if (i == 0) begin : g_first
			assign v_in = in_vld;
			assign r_in = '0;
			assign w_in = num;
			assign a_in = in_aux;
		end else begin : g_next
			assign v_in = vld_s[i-1];
			assign r_in = rem_s[i-1];
			assign w_in = wrk_s[i-1];
			assign a_in = aux_s[i-1];
		end

		assign t    = {r_in, w_in[NUM_W-1]};
		assign ge   = t >= {1'b0, den};
		assign diff = t - {1'b0, den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i] <= ge ? diff[DW-1:0] : t[DW-1:0];
			wrk_s[i] <= {w_in[NUM_W-2:0], ge};
			aux_s[i] <= a_in;
		end
	end

	assign out_vld = vld_s[NUM_W-1];
	assign quot    = wrk_s[NUM_W-1];
	assign rem     = rem_s[NUM_W-1];
	assign out_aux = aux_s[NUM_W-1];
endmodule

### rtl/volume_pad_index_map_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// volume_pad_index_map_top
// Maps a padded-volume voxel index to pad flag and source voxel index.
// ----------------------------------------------------------------------------
// Start to done runs through the two 35-stage bit-per-stage divider pipelines
// (x/y split, then y/z split) and three compare, multiply and sum stages.
// Throughput: one word per cycle; busy is never raised. Reset clears the valid
// bits and loads the register reset values.
module volume_pad_index_map_top
	import vpim_pkg::*;
#(
	parameter int MAX_SIZE = MAX_SIZE_DEF,
	parameter int MAX_PAD  = MAX_PAD_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [IDX_W-1:0]     out_index,
	output logic                 done,
	output logic                 is_pad,
	output logic [SRC_W-1:0]     source_index,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);
	localparam int LAT = 2 * IDX_W + 3;

	logic [CFG_W-1:0] w_q, h_q, d_q, pl_q, pr_q, pf_q, pbk_q, pbt_q;
	logic [2*CFG_W-1:0] wh_q;
	logic [CFG_W-1:0] sz_sat, pd_sat;
	logic [DEN_W-1:0] nx, ny;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	assign sz_sat = (32'(cfg_data) > 32'(MAX_SIZE)) ? CFG_W'(MAX_SIZE) : cfg_data;
	assign pd_sat = (32'(cfg_data) > 32'(MAX_PAD)) ? CFG_W'(MAX_PAD) : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q   <= CFG_W'(1);
			h_q   <= CFG_W'(1);
			d_q   <= CFG_W'(1);
			pl_q  <= '0;
			pr_q  <= '0;
			pf_q  <= '0;
			pbk_q <= '0;
			pbt_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_SRC_WIDTH:  w_q   <= sz_sat;
				REG_SRC_HEIGHT: h_q   <= sz_sat;
				REG_SRC_DEPTH:  d_q   <= sz_sat;
				REG_PAD_LEFT:   pl_q  <= pd_sat;
				REG_PAD_RIGHT:  pr_q  <= pd_sat;
				REG_PAD_FRONT:  pf_q  <= pd_sat;
				REG_PAD_BACK:   pbk_q <= pd_sat;
				REG_PAD_BOTTOM: pbt_q <= pd_sat;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		wh_q <= w_q * h_q;
	end

	assign nx = DEN_W'(w_q) + DEN_W'(pl_q) + DEN_W'(pr_q);
	assign ny = DEN_W'(h_q) + DEN_W'(pf_q) + DEN_W'(pbk_q);

	// x = idx % nx, then y/z from the quotient
	logic             v1;
	logic [IDX_W-1:0] q1;
	logic [DEN_W-1:0] x1, x2, y2, aux1_unused;
	logic             v2;
	logic [IDX_W-1:0] z2;

	vpim_div #(.NUM_W(IDX_W), .DW(DEN_W), .AUX_W(DEN_W)) u_div_x (
		.clk(clk), .arst_n(arst_n),
		.in_vld(start && !busy), .num(out_index), .den(nx), .in_aux('0),
		.out_vld(v1), .quot(q1), .rem(x1), .out_aux(aux1_unused)
	);

	vpim_div #(.NUM_W(IDX_W), .DW(DEN_W), .AUX_W(DEN_W)) u_div_y (
		.clk(clk), .arst_n(arst_n),
		.in_vld(v1 && (aux1_unused == aux1_unused)), .num(q1), .den(ny), .in_aux(x1),
		.out_vld(v2), .quot(z2), .rem(y2), .out_aux(x2)
	);

	// stage 1: bounds and offsets
	logic             zero_sz;
	logic             pad_c;
	logic             vld_s1, pad_s1;
	logic [CFG_W-1:0] xo_s1, yo_s1, zo_s1;

	assign zero_sz = (w_q == '0) || (h_q == '0) || (d_q == '0);
	assign pad_c = zero_sz
		|| (x2 < DEN_W'(pl_q)) || (x2 >= DEN_W'(pl_q) + DEN_W'(w_q))
		|| (y2 < DEN_W'(pf_q)) || (y2 >= DEN_W'(pf_q) + DEN_W'(h_q))
		|| (z2 < IDX_W'(pbt_q)) || (z2 >= IDX_W'(pbt_q) + IDX_W'(d_q));

	// stage 2: products
	logic                 vld_s2, pad_s2;
	logic [CFG_W-1:0]     xo_s2;
	logic [2*CFG_W-1:0]   py_s2;
	logic [3*CFG_W-1:0]   pz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= v2;
			vld_s2 <= vld_s1;
			done   <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		pad_s1 <= pad_c;
		xo_s1  <= CFG_W'(x2 - DEN_W'(pl_q));
		yo_s1  <= CFG_W'(y2 - DEN_W'(pf_q));
		zo_s1  <= CFG_W'(z2 - IDX_W'(pbt_q));

		pad_s2 <= pad_s1;
		xo_s2  <= xo_s1;
		py_s2  <= yo_s1 * w_q;
		pz_s2  <= zo_s1 * wh_q;

		is_pad       <= pad_s2;
		source_index <= pad_s2 ? '0
			: SRC_W'(xo_s2) + SRC_W'(py_s2) + pz_s2[SRC_W-1:0];
	end

	ap_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_pad) |-> (source_index == '0))
		else $error("pad word with nonzero source index");

	ap_empty_box: assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_sz) |-> is_pad)
		else $error("empty box gave a source voxel");

	ap_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !is_pad) |-> (64'(source_index) < 64'(wh_q) * 64'(d_q)))
		else $error("source index beyond source volume");

	ap_fill: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |=> done)
		else $error("word lost in output stage");

	logic unused_lat;
	assign unused_lat = (LAT == 0);
endmodule

### verif/volume_pad_index_map_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// volume_pad_index_map_top_tb
// Self-checking bench for the padded volume index map. Drives voxel indices
// under several volume and pad settings, predicts the pad flag and source
// index for each accepted word and checks every done strobe in order.
// ----------------------------------------------------------------------------
module volume_pad_index_map_top_tb;
	import vpim_pkg::*;

	localparam int LATENCY = 73;

	typedef struct {
		logic            pad;
		logic [SRC_W-1:0] src;
	} voxel_map_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [IDX_W-1:0]     out_index;
	logic                 done;
	logic                 is_pad;
	logic [SRC_W-1:0]     source_index;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	longint unsigned geom [8];
	voxel_map_t      map_q [$];
	int              mismatches;
	int              checked;

	volume_pad_index_map_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.out_index(out_index), .done(done), .is_pad(is_pad),
		.source_index(source_index), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("volume_pad_index_map_top_tb: FAIL");
		$finish;
	end

	function automatic voxel_map_t map_voxel(longint unsigned idx);
		voxel_map_t r;
		longint unsigned nx, ny, x, y, z, s;
		r.pad = 1'b1;
		r.src = '0;
		nx = geom[REG_SRC_WIDTH] + geom[REG_PAD_LEFT] + geom[REG_PAD_RIGHT];
		ny = geom[REG_SRC_HEIGHT] + geom[REG_PAD_FRONT] + geom[REG_PAD_BACK];
		if (geom[REG_SRC_WIDTH] == 0 || geom[REG_SRC_HEIGHT] == 0 ||
		    geom[REG_SRC_DEPTH] == 0 || nx == 0 || ny == 0)
			return r;
		x = idx % nx;
		y = (idx / nx) % ny;
		z = idx / (nx * ny);
		if (x < geom[REG_PAD_LEFT] || x >= geom[REG_PAD_LEFT] + geom[REG_SRC_WIDTH] ||
		    y < geom[REG_PAD_FRONT] || y >= geom[REG_PAD_FRONT] + geom[REG_SRC_HEIGHT] ||
		    z < geom[REG_PAD_BOTTOM] || z >= geom[REG_PAD_BOTTOM] + geom[REG_SRC_DEPTH])
			return r;
		s = (x - geom[REG_PAD_LEFT]) + (y - geom[REG_PAD_FRONT]) * geom[REG_SRC_WIDTH]
		  + (z - geom[REG_PAD_BOTTOM]) * geom[REG_SRC_WIDTH] * geom[REG_SRC_HEIGHT];
		r.pad = 1'b0;
		r.src = s[SRC_W-1:0];
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		voxel_map_t e;
		if (arst_n && done) begin
			if (map_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word: pad=%0b src=%0d", is_pad, source_index);
			end else begin
				e = map_q.pop_front();
				checked++;
				if (is_pad !== e.pad || source_index !== e.src) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp pad=%0b src=%0d, got pad=%0b src=%0d",
							e.pad, e.src, is_pad, source_index);
				end
			end
		end
	end

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if (n != 0) start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// start stays high on return so that words can follow back to back
	task automatic send_voxel(longint unsigned idx);
		start <= 1'b1;
		out_index <= idx[IDX_W-1:0];
		@(posedge clk);
		while (busy) @(posedge clk);
		map_q.push_back(map_voxel(idx));
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (map_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t ri, int unsigned val);
		logic [CFG_W-1:0] v;
		v = val[CFG_W-1:0];
		cfg_valid <= 1'b1;
		cfg_index <= ri;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (ri <= REG_SRC_DEPTH) geom[ri] = (v > MAX_SIZE_DEF) ? MAX_SIZE_DEF : v;
		else geom[ri] = (v > MAX_PAD_DEF) ? MAX_PAD_DEF : v;
		@(negedge clk);
	endtask

	task automatic set_geometry(int unsigned w, int unsigned h, int unsigned d, int unsigned pl,
		int unsigned pr, int unsigned pf, int unsigned pk, int unsigned pb);
		drain();
		write_reg(REG_SRC_WIDTH, w);
		write_reg(REG_SRC_HEIGHT, h);
		write_reg(REG_SRC_DEPTH, d);
		write_reg(REG_PAD_LEFT, pl);
		write_reg(REG_PAD_RIGHT, pr);
		write_reg(REG_PAD_FRONT, pf);
		write_reg(REG_PAD_BACK, pk);
		write_reg(REG_PAD_BOTTOM, pb);
		cfg_valid <= 1'b0;
	endtask

	function automatic longint unsigned padded_total();
		longint unsigned nx, ny, nz;
		nx = geom[REG_SRC_WIDTH] + geom[REG_PAD_LEFT] + geom[REG_PAD_RIGHT];
		ny = geom[REG_SRC_HEIGHT] + geom[REG_PAD_FRONT] + geom[REG_PAD_BACK];
		nz = geom[REG_PAD_BOTTOM] + geom[REG_SRC_DEPTH] + 2;
		return nx * ny * nz;
	endfunction

	function automatic longint unsigned rand_index();
		longint unsigned r;
		r = {$urandom(), $urandom()};
		if ($urandom_range(0, 7) == 0) return r % (64'd1 << IDX_W);
		return r % padded_total();
	endfunction

	task automatic test_reset_defaults();
		send_voxel(0);
		send_voxel(1);
		send_voxel({IDX_W{1'b1}});
	endtask

	task automatic test_directed_extremes();
		set_geometry(3, 2, 2, 1, 2, 1, 0, 1);
		for (int i = 0; i < 12; i++) send_voxel(i * 7);
		send_voxel(padded_total());
		// saturating writes and all-ones data
		set_geometry(2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047);
		send_voxel(0);
		send_voxel({IDX_W{1'b1}});
		send_voxel(64'd1024 + 64'd3072 * (64'd1024 + 64'd3072 * 64'd1024));
		// empty box
		set_geometry(0, 5, 5, 1, 1, 1, 1, 1);
		send_voxel(10);
		set_geometry(5, 0, 5, 0, 0, 0, 0, 0);
		send_voxel(3);
		set_geometry(5, 5, 0, 0, 0, 0, 0, 0);
		send_voxel(3);
	endtask

	task automatic test_random_geometries();
		for (int ph = 0; ph < 12; ph++) begin
			if (ph == 11)
				set_geometry(1024, 1024, 1024, 0, 0, 0, 0, 0);
			else
				set_geometry($urandom_range(1, 20), $urandom_range(1, 20), $urandom_range(1, 20),
					$urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 6),
					$urandom_range(0, 6), $urandom_range(0, 6));
			for (int i = 0; i < 150; i++) begin
				if ($urandom_range(0, 2) != 0) idle_gap();
				send_voxel(rand_index());
				if (i == 75) drain();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		out_index = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_SRC_WIDTH;
		cfg_data = '0;
		mismatches = 0;
		checked = 0;
		geom[REG_SRC_WIDTH] = 1;
		geom[REG_SRC_HEIGHT] = 1;
		geom[REG_SRC_DEPTH] = 1;
		for (int i = 3; i < 8; i++) geom[i] = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_directed_extremes();
		test_random_geometries();
		drain();
		if (mismatches == 0 && map_q.size() == 0)
			$display("volume_pad_index_map_top_tb: PASS");
		else
			$display("volume_pad_index_map_top_tb: FAIL");
		$finish;
	end
endmodule
